// File: rtl/sliding_window_anagram_matcher_unit_defines.svh
// ----------------------------------------------------------------------------
// Sliding window anagram matcher: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ANAGRAM_MATCHER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_ANAGRAM_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWAM_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWAM_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/swam_pkg.sv
// ----------------------------------------------------------------------------
// swam_pkg
// Types and fixed constants of the sliding window anagram matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package swam_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = 5;
    localparam int REQ_W         = 2;
    localparam int S_TDATA_W     = 8;

    // Request kinds on s_tuser
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

    // Output queue
    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int LVL_W     = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_PATTERN,
        OP_TEXT
    } op_t;

    // Control carried along the count update pipeline
    typedef struct packed {
        op_t                 op;
        logic [LETTER_W-1:0] sym;
        logic                has_e;   // entering letter count goes up
        logic                has_o;   // leaving / pattern letter count goes up
        logic                emit;    // window full after this item
    } stage_ctl_t;

    typedef struct packed {
        logic             not_empty;
        logic [LVL_W-1:0] level;
    } ofifo_status_t;

endpackage

`default_nettype wire

// File: rtl/swam_ram.sv
// ----------------------------------------------------------------------------
// swam_ram
// Generic single-write RAM with registered, read-first read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module swam_ram #(
    parameter int WIDTH    = 8,
    parameter int DEPTH    = 32,
    parameter int RD_PORTS = 1,
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr [RD_PORTS],
    output logic      [WIDTH-1:0]  rdata [RD_PORTS]
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        for (int i = 0; i < RD_PORTS; i++)
        begin
            rdata[i] <= mem[raddr[i]];
        end
    end

endmodule

`default_nettype wire

// File: rtl/swam_out_fifo.sv
// ----------------------------------------------------------------------------
// swam_out_fifo
// Small result queue decoupling the update pipeline from the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module swam_out_fifo
    import swam_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head_data,
    output ofifo_status_t         status
);

    logic [WIDTH-1:0]  slot_mem [OUT_DEPTH];
    logic [OPTR_W-1:0] wr_ptr_reg;
    logic [OPTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0]  count_reg;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    // push is never issued when full: the source holds credits for every slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OPTR_W'(1);
            end
            count_reg <= count_reg + LVL_W'(push) - LVL_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data        = slot_mem[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.level     = count_reg;

endmodule

`default_nettype wire

// File: rtl/sliding_window_anagram_matcher_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_anagram_matcher_unit
// Reports each text position where the last n letters are an anagram of the
// loaded n-letter pattern.
//
//   channel  dir  signals                       item
//   s_       in   tvalid tready tdata tuser     request: kind + letter
//   m_       out  tvalid tready tdata           match start index
//
// One item per cycle while s_tready is high. Each result passes the two
// update stages and the queue before it shows on m_; the rate is set by the
// read-modify-write of the two letter-count memories, closed each cycle by
// forwarding the last write. Reset is asynchronous; a clear item restores
// the same state in order. s_tready drops only when the 4-entry result queue
// plus the two update stages hold 4 items, i.e. while the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_anagram_matcher_unit
    import swam_pkg::*;
#(
    parameter int MAX_PATTERN   = 64,
    parameter int INDEX_BITS    = 16,
    localparam int OUT_TDATA_W  = ((INDEX_BITS + 7) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [4:0] symbol, rest zero
    input  wire logic [REQ_W-1:0]       s_tuser,   // [1:0] req_type
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata    // [INDEX_BITS-1:0] match_start
);

    localparam int PTR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int SLOT_W = LEN_W + 1;
    localparam int BAL_W  = LEN_W + 1;
    localparam int MS_W   = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
    localparam int NZ_W   = $clog2(ALPHABET_SIZE + 1);

    // ---------------- front end: window bookkeeping ----------------
    logic [LEN_W-1:0]      plen_reg,    plen_next;
    logic [LEN_W-1:0]      fill_reg,    fill_next;
    logic [PTR_W-1:0]      ptr_reg,     ptr_next;
    logic [INDEX_BITS-1:0] pos_reg,     pos_next;
    logic                  started_reg, started_next;

    logic                  in_acc;
    logic [REQ_W-1:0]      req;
    logic [LETTER_W-1:0]   sym;
    logic                  sym_ok;
    logic                  full;
    logic [LEN_W-1:0]      fill_inc;
    logic [SLOT_W-1:0]     slot_sum;
    logic [PTR_W-1:0]      old_slot;
    logic [PTR_W-1:0]      ptr_inc;
    logic [MS_W-1:0]       ms_full;
    logic                  hist_we;

    logic                  s1_valid_reg, s1_valid_next;
    stage_ctl_t            s1_ctl_reg,   s1_ctl_next;
    logic [INDEX_BITS-1:0] s1_ms_reg;

    logic [PTR_W-1:0]      h_raddr [1];
    logic [LETTER_W-1:0]   h_rdata [1];

    assign in_acc   = s_tvalid && s_tready;
    assign req      = s_tuser;
    assign sym      = s_tdata[LETTER_W-1:0];
    assign sym_ok   = (sym < LETTER_W'(ALPHABET_SIZE));
    assign full     = (fill_reg == plen_reg);
    assign fill_inc = fill_reg + LEN_W'(1);
    assign ptr_inc  = (ptr_reg == PTR_W'(MAX_PATTERN - 1)) ? '0 : ptr_reg + PTR_W'(1);
    assign ms_full  = MS_W'(pos_reg) - MS_W'(plen_reg) + MS_W'(1);

    // slot of the letter leaving the window
    assign slot_sum = SLOT_W'(ptr_reg) + SLOT_W'(MAX_PATTERN) - SLOT_W'(plen_reg);
    always_comb
    begin
        if (slot_sum >= SLOT_W'(MAX_PATTERN))
        begin
            old_slot = PTR_W'(slot_sum - SLOT_W'(MAX_PATTERN));
        end
        else
        begin
            old_slot = PTR_W'(slot_sum);
        end
    end
    assign h_raddr[0] = old_slot;

    always_comb
    begin
        plen_next      = plen_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        hist_we        = 1'b0;
        s1_valid_next  = 1'b0;
        s1_ctl_next.op    = OP_CLEAR;
        s1_ctl_next.sym   = sym;
        s1_ctl_next.has_e = 1'b0;
        s1_ctl_next.has_o = 1'b0;
        s1_ctl_next.emit  = 1'b0;
        if (in_acc)
        begin
            unique case (req)
                REQ_CLEAR:
                begin
                    plen_next     = '0;
                    fill_next     = '0;
                    ptr_next      = '0;
                    pos_next      = '0;
                    started_next  = 1'b0;
                    s1_valid_next = 1'b1;
                end
                REQ_PATTERN:
                begin
                    if (sym_ok && !started_reg && (plen_reg < LEN_W'(MAX_PATTERN)))
                    begin
                        plen_next         = plen_reg + LEN_W'(1);
                        s1_valid_next     = 1'b1;
                        s1_ctl_next.op    = OP_PATTERN;
                        s1_ctl_next.has_o = 1'b1;
                    end
                end
                REQ_TEXT:
                begin
                    if (sym_ok)
                    begin
                        started_next = 1'b1;
                        pos_next     = pos_reg + INDEX_BITS'(1);
                        if (plen_reg != '0)
                        begin
                            hist_we           = 1'b1;
                            ptr_next          = ptr_inc;
                            s1_valid_next     = 1'b1;
                            s1_ctl_next.op    = OP_TEXT;
                            s1_ctl_next.has_e = 1'b1;
                            s1_ctl_next.has_o = full;
                            s1_ctl_next.emit  = full || (fill_inc == plen_reg);
                            if (!full)
                            begin
                                fill_next = fill_inc;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // history ring: read-first, so a full ring of MAX_PATTERN still sees the
    // leaving letter when the write lands on the same slot
    swam_ram #(
        .WIDTH    (LETTER_W),
        .DEPTH    (MAX_PATTERN),
        .RD_PORTS (1)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ptr_reg),
        .wdata (sym),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // ---------------- count pipeline ----------------
    // balance = enter_count - (pattern + leave_count), each half its own RAM
    logic                  s2_valid_reg;
    stage_ctl_t            s2_ctl_reg;
    logic [LETTER_W-1:0]   s2_o_reg;
    logic [INDEX_BITS-1:0] s2_ms_reg;
    logic [LETTER_W-1:0]   s1_o;

    logic [LETTER_W-1:0]   bal_raddr [2];
    logic [BAL_W-1:0]      a_rdata   [2];
    logic [BAL_W-1:0]      r_rdata   [2];

    logic [ALPHABET_SIZE-1:0] va_reg;
    logic [ALPHABET_SIZE-1:0] vr_reg;
    logic                  fa_v_reg;
    logic [LETTER_W-1:0]   fa_addr_reg;
    logic [BAL_W-1:0]      fa_data_reg;
    logic                  fr_v_reg;
    logic [LETTER_W-1:0]   fr_addr_reg;
    logic [BAL_W-1:0]      fr_data_reg;
    logic [NZ_W-1:0]       nz_reg, nz_next;

    logic [BAL_W-1:0]      a_e, a_o, r_e, r_o;
    logic [BAL_W-1:0]      bal_e, bal_o;
    logic [BAL_W-1:0]      a_wdata, r_wdata;
    logic                  a_we, r_we;
    logic                  same;
    logic                  e_was, e_now, o_was, o_now;
    logic                  up_e, dn_e, up_o, dn_o;
    logic                  push;

    assign s1_o         = (s1_ctl_reg.op == OP_PATTERN) ? s1_ctl_reg.sym : h_rdata[0];
    assign bal_raddr[0] = s1_ctl_reg.sym;
    assign bal_raddr[1] = s1_o;

    // last write wins over the RAM; a never-written letter reads as zero
    always_comb
    begin
        a_e = va_reg[s2_ctl_reg.sym] ? a_rdata[0] : '0;
        a_o = va_reg[s2_o_reg]       ? a_rdata[1] : '0;
        r_e = vr_reg[s2_ctl_reg.sym] ? r_rdata[0] : '0;
        r_o = vr_reg[s2_o_reg]       ? r_rdata[1] : '0;
        if (fa_v_reg && (fa_addr_reg == s2_ctl_reg.sym))
        begin
            a_e = fa_data_reg;
        end
        if (fa_v_reg && (fa_addr_reg == s2_o_reg))
        begin
            a_o = fa_data_reg;
        end
        if (fr_v_reg && (fr_addr_reg == s2_ctl_reg.sym))
        begin
            r_e = fr_data_reg;
        end
        if (fr_v_reg && (fr_addr_reg == s2_o_reg))
        begin
            r_o = fr_data_reg;
        end
    end

    assign bal_e   = a_e - r_e;
    assign bal_o   = a_o - r_o;
    assign a_wdata = a_e + BAL_W'(1);
    assign r_wdata = r_o + BAL_W'(1);
    assign a_we    = s2_valid_reg && s2_ctl_reg.has_e;
    assign r_we    = s2_valid_reg && s2_ctl_reg.has_o;

    // same letter entering and leaving leaves the balance unchanged
    assign same  = s2_ctl_reg.has_e && s2_ctl_reg.has_o && (s2_ctl_reg.sym == s2_o_reg);
    assign e_was = (bal_e != '0);
    assign e_now = ((bal_e + BAL_W'(1)) != '0);
    assign o_was = (bal_o != '0);
    assign o_now = ((bal_o - BAL_W'(1)) != '0);
    assign up_e  = s2_ctl_reg.has_e && !same && !e_was && e_now;
    assign dn_e  = s2_ctl_reg.has_e && !same && e_was && !e_now;
    assign up_o  = s2_ctl_reg.has_o && !same && !o_was && o_now;
    assign dn_o  = s2_ctl_reg.has_o && !same && o_was && !o_now;
    assign nz_next = nz_reg + NZ_W'(up_e) + NZ_W'(up_o) - NZ_W'(dn_e) - NZ_W'(dn_o);

    assign push = s2_valid_reg && (s2_ctl_reg.op == OP_TEXT) && s2_ctl_reg.emit
                  && (nz_next == '0);

    swam_ram #(
        .WIDTH    (BAL_W),
        .DEPTH    (ALPHABET_SIZE),
        .RD_PORTS (2)
    ) u_enter_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (s2_ctl_reg.sym),
        .wdata (a_wdata),
        .raddr (bal_raddr),
        .rdata (a_rdata)
    );

    swam_ram #(
        .WIDTH    (BAL_W),
        .DEPTH    (ALPHABET_SIZE),
        .RD_PORTS (2)
    ) u_leave_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (s2_o_reg),
        .wdata (r_wdata),
        .raddr (bal_raddr),
        .rdata (r_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= '0;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            pos_reg      <= '0;
            started_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            va_reg       <= '0;
            vr_reg       <= '0;
            fa_v_reg     <= 1'b0;
            fa_addr_reg  <= '0;
            fa_data_reg  <= '0;
            fr_v_reg     <= 1'b0;
            fr_addr_reg  <= '0;
            fr_data_reg  <= '0;
            nz_reg       <= '0;
        end
        else
        begin
            plen_reg     <= plen_next;
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            pos_reg      <= pos_next;
            started_reg  <= started_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_ctl_reg.op == OP_CLEAR)
                begin
                    va_reg   <= '0;
                    vr_reg   <= '0;
                    fa_v_reg <= 1'b0;
                    fr_v_reg <= 1'b0;
                    nz_reg   <= '0;
                end
                else
                begin
                    nz_reg <= nz_next;
                    if (a_we)
                    begin
                        va_reg[s2_ctl_reg.sym] <= 1'b1;
                        fa_v_reg    <= 1'b1;
                        fa_addr_reg <= s2_ctl_reg.sym;
                        fa_data_reg <= a_wdata;
                    end
                    if (r_we)
                    begin
                        vr_reg[s2_o_reg] <= 1'b1;
                        fr_v_reg    <= 1'b1;
                        fr_addr_reg <= s2_o_reg;
                        fr_data_reg <= r_wdata;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg <= s1_ctl_next;
        s1_ms_reg  <= ms_full[INDEX_BITS-1:0];
        s2_ctl_reg <= s1_ctl_reg;
        s2_o_reg   <= s1_o;
        s2_ms_reg  <= s1_ms_reg;
    end

    // ---------------- output queue ----------------
    ofifo_status_t        ofifo_st;
    logic [LVL_W-1:0]     committed;

    swam_out_fifo #(
        .WIDTH (OUT_TDATA_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (OUT_TDATA_W'(s2_ms_reg)),
        .pop       (m_tready),
        .head_data (m_tdata),
        .status    (ofifo_st)
    );

    // every item in the two update stages holds a queue slot in reserve
    assign committed = ofifo_st.level + LVL_W'(s1_valid_reg) + LVL_W'(s2_valid_reg);
    assign s_tready  = (committed < LVL_W'(OUT_DEPTH));
    assign m_tvalid  = ofifo_st.not_empty;

endmodule

`default_nettype wire

// File: rtl/swam_checker.sv
// ----------------------------------------------------------------------------
// swam_checker
// Port-level checks of the anagram matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_anagram_matcher_unit_defines.svh"

module swam_checker
    import swam_pkg::*;
#(
    parameter int INDEX_BITS   = 16,
    localparam int OUT_TDATA_W = ((INDEX_BITS + 7) / 8) * 8
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [S_TDATA_W-1:0]   s_tdata,
    input wire logic [REQ_W-1:0]       s_tuser,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic text_acc;
    logic sym_ok;

    assign sym_ok   = (s_tdata[LETTER_W-1:0] < LETTER_W'(ALPHABET_SIZE));
    assign text_acc = s_tvalid && s_tready && (s_tuser == REQ_TEXT) && sym_ok;

    // a held result keeps its value
    `SWAM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    // an empty queue refills only from an earlier accepted text item
    `SWAM_ASSERT_NOW(a_out_source, clk, rst_n, $rose(m_tvalid),
        $past(text_acc, 3), "result without a matching text item")

    // input backpressure only while results are waiting
    `SWAM_ASSERT_NOW(a_ready_cause, clk, rst_n, !s_tready,
        m_tvalid, "input stalled with no pending result")

endmodule

bind sliding_window_anagram_matcher_unit swam_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_swam_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: sliding window anagram matcher regression
// Streams clear, pattern and text items into the block, predicts every match
// start index in a scoreboard model kept here, and checks each output item in
// order. Three traffic phases vary sender and receiver idling. A long receiver
// hold and a maximum-length pattern run are also part of the regression.
// ----------------------------------------------------------------------------
module tb;
    import swam_pkg::*;

    localparam int WINDOW_MAX   = 64;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 250;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 10;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [LETTER_W-1:0] sym;
    } request_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // [4:0] symbol, rest zero
    logic [REQ_W-1:0]     s_tuser = '0;    // [1:0] req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;         // [15:0] match_start

    sliding_window_anagram_matcher_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // traffic control, written by the stimulus process at the falling edge
    request_t    pending_q[$];
    logic [15:0] match_q[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req_seq  = 0;
    int          planned_items = 0;

    int          items_accepted = 0;
    int          matches_checked = 0;
    int          mismatches = 0;

    // ------------------------------------------------------------------
    // Matcher model
    // ------------------------------------------------------------------
    int          tally[ALPHABET_SIZE];   // text count minus pattern count
    int          unbalanced;             // letters with nonzero tally
    int          pat_len;
    int          win_len;
    int          recent[WINDOW_MAX];
    int          slot;
    logic [15:0] next_index;
    bit          text_seen;

    function automatic void clear_matcher();
        foreach (tally[i])
            tally[i] = 0;
        foreach (recent[i])
            recent[i] = 0;
        unbalanced = 0;
        pat_len    = 0;
        win_len    = 0;
        slot       = 0;
        next_index = '0;
        text_seen  = 1'b0;
    endfunction

    function automatic void bump_tally(input int letter, input int delta);
        bit was_set;
        if (letter >= ALPHABET_SIZE)
            return;
        was_set = (tally[letter] != 0);
        tally[letter] += delta;
        if (!was_set && tally[letter] != 0)
            unbalanced++;
        else if (was_set && tally[letter] == 0)
            unbalanced--;
    endfunction

    function automatic void apply_request(input logic [REQ_W-1:0] req,
                                          input logic [LETTER_W-1:0] sym,
                                          output bit hit, output logic [15:0] start);
        int leaving;
        hit   = 1'b0;
        start = '0;
        if (req == REQ_CLEAR)
        begin
            clear_matcher();
            return;
        end
        if (req == REQ_UNKNOWN || sym >= ALPHABET_SIZE)
            return;
        if (req == REQ_PATTERN)
        begin
            if (!text_seen && pat_len < WINDOW_MAX)
            begin
                bump_tally(sym, -1);
                pat_len++;
            end
            return;
        end
        text_seen = 1'b1;
        if (pat_len > 0)
        begin
            if (win_len == pat_len)
            begin
                leaving = recent[(slot + WINDOW_MAX - pat_len) % WINDOW_MAX];
                bump_tally(leaving, -1);
            end
            else
                win_len++;
            bump_tally(sym, 1);
            recent[slot] = sym;
            slot = (slot + 1) % WINDOW_MAX;
            if (win_len == pat_len && unbalanced == 0)
            begin
                hit   = 1'b1;
                start = 16'(int'(next_index) - pat_len + 1);
            end
        end
        next_index++;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        bit          hit;
        logic [15:0] start;
        request_t    nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            clear_matcher();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser, s_tdata[LETTER_W-1:0], hit, start);
                if (hit)
                    match_q.push_back(start);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.req;
                    s_tdata  <= {{(S_TDATA_W-LETTER_W){1'b0}}, nxt.sym};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Match monitor and receiver backpressure
    // ------------------------------------------------------------------
    int hold_seen_seq = 0;
    int hold_left     = 0;

    always @(posedge clk or negedge rst_n)
    begin : check_matches
        logic [15:0] want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (match_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected match item, match_start=%0d",
                                 $realtime, m_tdata);
                end
                else
                begin
                    want = match_q.pop_front();
                    matches_checked++;
                    if (m_tdata !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: match_start mismatch, expected %0d got %0d",
                                     $realtime, want, m_tdata);
                    end
                end
            end
            if (hold_req_seq != hold_seen_seq)
            begin
                hold_seen_seq <= hold_req_seq;
                hold_left     <= HOLD_CYCLES;
                m_tready      <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no item moving on either side for too long
    // ------------------------------------------------------------------
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d matches outstanding",
                         $realtime, stuck_cycles, match_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic [REQ_W-1:0] req, input int sym);
        request_t it;
        it.req = req;
        it.sym = LETTER_W'(sym);
        pending_q.push_back(it);
        planned_items++;
    endtask

    task automatic push_noise();
        case ($urandom_range(3))
            0:       push_item(REQ_UNKNOWN, $urandom_range(31));
            1:       push_item(REQ_PATTERN, $urandom_range(ALPHABET_SIZE, 31));
            2:       push_item(REQ_TEXT, $urandom_range(ALPHABET_SIZE, 31));
            default: push_item(REQ_PATTERN, $urandom_range(ALPHABET_SIZE - 1));
        endcase
    endtask

    // one (usually cleared) pattern / text run; letters come mostly from a tiny set so that
    // anagram windows are frequent
    task automatic push_anagram_run(input int forced_len);
        int letters[3];
        int plen;
        int tlen;
        int pick;
        foreach (letters[i])
            letters[i] = $urandom_range(ALPHABET_SIZE - 1);
        if (forced_len > 0)
            plen = forced_len;
        else
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                plen = $urandom_range(1, 6);
            else if (pick < 95)
                plen = $urandom_range(7, WINDOW_MAX);
            else
                plen = $urandom_range(WINDOW_MAX + 1, WINDOW_MAX + 6);
        end
        if ($urandom_range(19) != 0)
            push_item(REQ_CLEAR, $urandom_range(31));
        for (int k = 0; k < plen; k++)
        begin
            if ($urandom_range(99) < 4)
                push_noise();
            push_item(REQ_PATTERN, letters[$urandom_range(2)]);
        end
        tlen = ((plen > WINDOW_MAX) ? WINDOW_MAX : plen) + $urandom_range(40);
        for (int k = 0; k < tlen; k++)
        begin
            pick = $urandom_range(199);
            if (pick < 170)
                push_item(REQ_TEXT, letters[$urandom_range(2)]);
            else if (pick < 186)
                push_item(REQ_TEXT, $urandom_range(ALPHABET_SIZE - 1));
            else if (pick < 198)
                push_noise();
            else
                push_item(REQ_CLEAR, $urandom_range(31));
        end
    endtask

    // stimulus waits until every queued item is sent and every expected match returned
    task automatic drain();
        while (pending_q.size() != 0 || s_tvalid || match_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phase 1: sparse receiver
        send_idle_pct = 28;
        recv_idle_pct = 87;

        // directed: empty pattern, late pattern, ignored items, extreme letters
        push_item(REQ_TEXT, 0);
        push_item(REQ_PATTERN, 1);
        push_item(REQ_CLEAR, 31);
        push_item(REQ_UNKNOWN, 31);
        push_item(REQ_PATTERN, 26);
        push_item(REQ_PATTERN, 31);
        push_item(REQ_PATTERN, 0);
        push_item(REQ_PATTERN, 25);
        push_item(REQ_TEXT, 25);
        push_item(REQ_TEXT, 0);
        push_item(REQ_TEXT, 31);
        push_item(REQ_TEXT, 0);
        push_item(REQ_TEXT, 25);
        push_item(REQ_PATTERN, 1);
        push_item(REQ_UNKNOWN, 0);
        push_item(REQ_TEXT, 25);
        push_item(REQ_CLEAR, 0);
        push_item(REQ_PATTERN, 2);
        push_item(REQ_PATTERN, 2);
        push_item(REQ_TEXT, 2);
        push_item(REQ_TEXT, 2);
        push_item(REQ_TEXT, 2);
        drain();

        while (planned_items < 580)
            push_anagram_run(0);
        drain();

        // phase 2: sparse sender
        send_idle_pct = 87;
        recv_idle_pct = 28;
        while (planned_items < 1160)
            push_anagram_run(0);
        drain();

        // phase 3: full rate; first a long output hold so the input stalls
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_seq++;
        push_item(REQ_CLEAR, 0);
        push_item(REQ_PATTERN, 0);
        for (int k = 0; k < 40; k++)
            push_item(REQ_TEXT, 0);
        drain();

        while (planned_items < 1580)
            push_anagram_run(0);
        push_anagram_run(WINDOW_MAX + 5);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests in three idling phases, an output hold and a full window;",
                 items_accepted);
        $display("checked %0d match items, %0d mismatches.", matches_checked, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/swam_pkg.sv
rtl/swam_ram.sv
rtl/swam_out_fifo.sv
rtl/sliding_window_anagram_matcher_unit.sv
rtl/swam_checker.sv
tb/tb.sv
